### design/mfdl_pkg.sv
// Shared widths, rounding constants and types for the modulated fractional delay line.
// No dependencies; the core and the testbench use it by scoped names.
`default_nettype none

package mfdl_pkg;

  localparam int SAMPLE_W = 16;              // audio sample
  localparam int DELAY_W  = 17;              // delay amount, Q1.16 up to 1.0
  localparam int MOD_W    = 16;              // modulation depth, Q8.8
  localparam int FRAC_W   = 16;              // fraction bits of the read position
  localparam int MOD_SH   = 8;               // Q8.8 * Q0.16 -> 16 fraction bits
  localparam int MODP_W   = MOD_W + DELAY_W + 1;
  localparam int PROD_W   = SAMPLE_W + 1 + FRAC_W + 1;
  localparam int ACC_W    = PROD_W + 1;

  localparam logic [DELAY_W-1:0] DELAY_ONE = DELAY_W'(65536);
  localparam int MOD_RND = 128;              // half of 2^MOD_SH
  localparam int OUT_RND = 32768;            // half of 2^FRAC_W

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [DELAY_W-1:0]  delay_t;
  typedef logic signed [MOD_W-1:0]    mod_t;
  typedef logic        [FRAC_W-1:0]   frac_t;

endpackage

`default_nettype wire

### design/modulated_fractional_delay_line_core.sv
// Modulated fractional delay line: sequencer, position arithmetic and linear interpolation
// around one single-port sample store. Depends on mfdl_pkg and mfdl_ram.
// Sequence per item: accept and write the sample, multiply, form the read position, wrap it
// (at most one buffer-length correction of the read index), read both taps, multiply, output.
// A new item is accepted only back in idle, after the previous result is registered at the output.
// Reset: write pointer to zero, store reads as zero until each entry is first written.
`default_nettype none

module modulated_fractional_delay_line_core #(
  parameter int BUFFER_DEPTH = 16384
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output      logic                    in_stall,
  input  wire mfdl_pkg::sample_t       in_sample_in,
  input  wire mfdl_pkg::delay_t        in_delay_amount,
  input  wire mfdl_pkg::mod_t          in_mod_depth,
  output      logic                    out_valid,
  input  wire logic                    out_stall,
  output      mfdl_pkg::sample_t       out_sample_out
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int HW = (AW > 8) ? AW : 8;
  localparam int PW = HW + 18;                       // signed position, 16 fraction bits
  localparam int IW = PW - mfdl_pkg::FRAC_W;         // signed integer part
  localparam int DW = mfdl_pkg::DELAY_W + AW;        // delay term
  localparam logic signed [IW-1:0] DEPTH_S = IW'(BUFFER_DEPTH);
  localparam logic [AW:0]          DEPTH_U = (AW + 1)'(BUFFER_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_POS, S_WRAP, S_RDB, S_IMUL, S_OUT
  } state_t;

  state_t                                   state_r, state_nxt;
  logic [AW-1:0]                            wp_r, wp_nxt;
  logic                                     full_r, full_nxt;
  mfdl_pkg::delay_t                         dly_r, dly_nxt;
  mfdl_pkg::mod_t                           mod_r, mod_nxt;
  logic signed [mfdl_pkg::MODP_W-1:0]       modp_r, modp_nxt;
  logic [DW-1:0]                            dlyp_r, dlyp_nxt;
  logic signed [IW-1:0]                     idx_r, idx_nxt;
  mfdl_pkg::frac_t                          frac_r, frac_nxt;
  logic [AW-1:0]                            nidx_r, nidx_nxt;
  logic                                     a_ok_r, a_ok_nxt;
  logic                                     b_ok_r, b_ok_nxt;
  mfdl_pkg::sample_t                        a_r, a_nxt;
  logic signed [mfdl_pkg::PROD_W-1:0]       prod_r, prod_nxt;
  logic                                     out_valid_r, out_valid_nxt;
  mfdl_pkg::sample_t                        out_data_r, out_data_nxt;

  logic                                     ram_we;
  logic [AW-1:0]                            ram_addr;
  mfdl_pkg::sample_t                        ram_rdata;

  logic [AW:0]                              wp_inc;
  logic [AW-1:0]                            wp_wrap;
  logic [AW-1:0]                            ridx;
  logic [AW:0]                              ridx_inc;
  logic                                     ridx_ok;
  logic                                     nidx_ok;
  mfdl_pkg::delay_t                         dly_sat;
  mfdl_pkg::delay_t                         dly_inv;
  logic signed [mfdl_pkg::MODP_W-1:0]       mod_rnd;
  logic signed [PW-1:0]                     pos;
  mfdl_pkg::sample_t                        b_val;
  logic signed [mfdl_pkg::SAMPLE_W:0]       diff;
  logic signed [mfdl_pkg::ACC_W-1:0]        acc;

  mfdl_ram #(
    .WIDTH (mfdl_pkg::SAMPLE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_sample_in),
    .rdata (ram_rdata)
  );

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

  // pointer and index arithmetic
  assign wp_inc   = {1'b0, wp_r} + (AW + 1)'(1);
  assign wp_wrap  = (wp_inc == DEPTH_U) ? '0 : wp_inc[AW-1:0];
  assign ridx     = idx_r[AW-1:0];
  assign ridx_inc = {1'b0, ridx} + (AW + 1)'(1);
  // entries 1..wp_r are filled until the first write of entry 0
  assign ridx_ok  = full_r || ((ridx != '0) && (ridx <= wp_r));
  assign nidx_ok  = full_r || ((nidx_r != '0) && (nidx_r <= wp_r));

  assign dly_sat  = (in_delay_amount > mfdl_pkg::DELAY_ONE) ? mfdl_pkg::DELAY_ONE
                                                            : in_delay_amount;
  assign dly_inv  = mfdl_pkg::DELAY_ONE - dly_r;
  assign mod_rnd  = modp_r + mfdl_pkg::MODP_W'(mfdl_pkg::MOD_RND);
  assign pos      = (PW'(wp_r) << mfdl_pkg::FRAC_W)
                  - PW'(mod_rnd >>> mfdl_pkg::MOD_SH)
                  - PW'(dlyp_r);

  assign b_val    = b_ok_r ? ram_rdata : '0;
  assign diff     = (mfdl_pkg::SAMPLE_W + 1)'(b_val) - (mfdl_pkg::SAMPLE_W + 1)'(a_r);
  assign acc      = (mfdl_pkg::ACC_W'(a_r) <<< mfdl_pkg::FRAC_W)
                  + mfdl_pkg::ACC_W'(prod_r)
                  + mfdl_pkg::ACC_W'(mfdl_pkg::OUT_RND);

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    full_nxt      = full_r;
    dly_nxt       = dly_r;
    mod_nxt       = mod_r;
    modp_nxt      = modp_r;
    dlyp_nxt      = dlyp_r;
    idx_nxt       = idx_r;
    frac_nxt      = frac_r;
    nidx_nxt      = nidx_r;
    a_ok_nxt      = a_ok_r;
    b_ok_nxt      = b_ok_r;
    a_nxt         = a_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_addr      = ridx;

    case (state_r)
      S_IDLE: begin
        ram_addr = wp_wrap;
        if (in_valid) begin
          ram_we    = 1'b1;
          wp_nxt    = wp_wrap;
          full_nxt  = full_r || (wp_wrap == '0);
          dly_nxt   = dly_sat;
          mod_nxt   = in_mod_depth;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        modp_nxt  = mfdl_pkg::MODP_W'(mod_r)
                  * mfdl_pkg::MODP_W'(signed'({1'b0, dly_inv}));
        dlyp_nxt  = DW'(dly_r) * DW'(BUFFER_DEPTH - 1);
        state_nxt = S_POS;
      end
      S_POS: begin
        idx_nxt   = pos[PW-1:mfdl_pkg::FRAC_W];
        frac_nxt  = pos[mfdl_pkg::FRAC_W-1:0];
        state_nxt = S_WRAP;
      end
      S_WRAP: begin
        if (idx_r < 0) begin
          idx_nxt = idx_r + DEPTH_S;
        end else if (idx_r >= DEPTH_S) begin
          idx_nxt = idx_r - DEPTH_S;
        end else begin
          ram_addr  = ridx;
          a_ok_nxt  = ridx_ok;
          nidx_nxt  = (ridx_inc == DEPTH_U) ? '0 : ridx_inc[AW-1:0];
          state_nxt = S_RDB;
        end
      end
      S_RDB: begin
        ram_addr  = nidx_r;
        a_nxt     = a_ok_r ? ram_rdata : '0;
        b_ok_nxt  = nidx_ok;
        state_nxt = S_IMUL;
      end
      S_IMUL: begin
        prod_nxt  = mfdl_pkg::PROD_W'(diff)
                  * mfdl_pkg::PROD_W'(signed'({1'b0, frac_r}));
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = acc[mfdl_pkg::FRAC_W +: mfdl_pkg::SAMPLE_W];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dly_r      <= dly_nxt;
    mod_r      <= mod_nxt;
    modp_r     <= modp_nxt;
    dlyp_r     <= dlyp_nxt;
    idx_r      <= idx_nxt;
    frac_r     <= frac_nxt;
    nidx_r     <= nidx_nxt;
    a_ok_r     <= a_ok_nxt;
    b_ok_r     <= b_ok_nxt;
    a_r        <= a_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

### design/mfdl_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module mfdl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

### test/tb_modulated_fractional_delay_line_core.sv
// Self-checking testbench for modulated_fractional_delay_line_core: random and directed items
// with idle gaps and backpressure on both channels, checked by a predictor in a scoreboard class.
// Depends on mfdl_pkg and the core RTL.
`default_nettype none

module tb_modulated_fractional_delay_line_core;

  localparam int DEPTH        = 16384;
  localparam int RANDOM_ITEMS = 1150;
  localparam int BURST_ITEMS  = 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 32;
  localparam int CYCLE_LIMIT  = 1500000;

  class tap_scoreboard;
    mfdl_pkg::sample_t echo_mem [DEPTH];
    int                head;
    mfdl_pkg::sample_t pending_taps [$];
    int                errors;
    int                items;
    int                taps_checked;
    int                wraps;

    function new();
      foreach (echo_mem[i]) echo_mem[i] = '0;
      head = 0;
      errors = 0;
      items = 0;
      taps_checked = 0;
      wraps = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    // write the sample, then interpolate between the two taps around the read position
    function void note_sample(mfdl_pkg::sample_t s, mfdl_pkg::delay_t d, mfdl_pkg::mod_t m);
      longint dly, mod_term, dly_term, span, pos, frac, a, b, acc;
      int idx, nxt;
      dly = (d > mfdl_pkg::DELAY_ONE) ? longint'(mfdl_pkg::DELAY_ONE) : longint'(d);
      head = (head + 1) % DEPTH;
      if (head == 0) wraps++;
      echo_mem[head] = s;
      mod_term = (longint'(m) * (65536 - dly) + mfdl_pkg::MOD_RND) >>> mfdl_pkg::MOD_SH;
      dly_term = dly * (DEPTH - 1);
      span = longint'(DEPTH) << mfdl_pkg::FRAC_W;
      pos = (longint'(head) << mfdl_pkg::FRAC_W) - mod_term - dly_term;
      pos = pos % span;
      if (pos < 0) pos += span;
      idx = int'(pos >>> mfdl_pkg::FRAC_W) % DEPTH;
      frac = pos & 65535;
      nxt = (idx + 1) % DEPTH;
      a = longint'(echo_mem[idx]);
      b = longint'(echo_mem[nxt]);
      acc = a * 65536 + (b - a) * frac + mfdl_pkg::OUT_RND;
      pending_taps.push_back(mfdl_pkg::sample_t'(acc >>> mfdl_pkg::FRAC_W));
      items++;
    endfunction

    task check_tap(mfdl_pkg::sample_t got);
      mfdl_pkg::sample_t want;
      if (pending_taps.size() == 0) begin
        report($sformatf("unexpected result sample_out=%0d", got));
        return;
      end
      want = pending_taps.pop_front();
      taps_checked++;
      if (got !== want)
        report($sformatf("result %0d sample_out=%0d, expected %0d", taps_checked, got, want));
    endtask

    function int pending();
      return pending_taps.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  mfdl_pkg::sample_t in_sample_in;
  mfdl_pkg::delay_t  in_delay_amount;
  mfdl_pkg::mod_t    in_mod_depth;
  logic              out_valid;
  logic              out_stall;
  mfdl_pkg::sample_t out_sample_out;

  bit quiet;
  bit hold_req;
  int cycles = 0;

  tap_scoreboard sb;

  modulated_fractional_delay_line_core #(
    .BUFFER_DEPTH(DEPTH)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .in_delay_amount(in_delay_amount),
    .in_mod_depth   (in_mod_depth),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("[modulated_fractional_delay_line_core] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_tap(out_sample_out);
  end

  // receiver: random stall per item, or a long hold when asked
  initial begin
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req) n = HOLD_CYCLES;
      else if (quiet) n = 0;
      else n = $urandom_range(0, 10);
      hold_req = 1'b0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic int pick_gap();
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic mfdl_pkg::sample_t pick_sample();
    if ($urandom_range(0, 3) == 0)
      return mfdl_pkg::sample_t'(int'($urandom_range(0, 512)) - 256);
    return mfdl_pkg::sample_t'($urandom());
  endfunction

  function automatic mfdl_pkg::delay_t pick_delay();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return mfdl_pkg::DELAY_ONE;
      2:       return mfdl_pkg::delay_t'($urandom_range(65537, 131071));
      3, 4, 5, 6: return mfdl_pkg::delay_t'($urandom_range(0, 4096));
      default: return mfdl_pkg::delay_t'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic mfdl_pkg::mod_t pick_mod();
    if ($urandom_range(0, 1) == 0)
      return mfdl_pkg::mod_t'(int'($urandom_range(0, 4096)) - 2048);
    return mfdl_pkg::mod_t'($urandom());
  endfunction

  task automatic send_item(input mfdl_pkg::sample_t s, input mfdl_pkg::delay_t d,
                           input mfdl_pkg::mod_t m, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_in    <= s;
    in_delay_amount <= d;
    in_mod_depth    <= m;
    do @(posedge clk); while (in_stall);
    sb.note_sample(s, d, m);
  endtask

  task automatic send_random();
    send_item(pick_sample(), pick_delay(), pick_mod(), pick_gap());
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    in_valid        <= 1'b0;
    in_sample_in    <= '0;
    in_delay_amount <= '0;
    in_mod_depth    <= '0;
    rst_n           <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items
    send_item(16'sh7FFF, '0, '0, pick_gap());
    send_item(-16'sh8000, '0, '0, pick_gap());
    send_item(16'sd1000, '0, 16'sh0080, pick_gap());
    send_item(-16'sd1000, '0, 16'sh7FFF, pick_gap());
    send_item(16'sd12345, '0, -16'sh8000, pick_gap());
    send_item(16'sd77, '0, mfdl_pkg::mod_t'((sb.head + 1) * 256 + 128), pick_gap());
    send_item(16'sh7FFF, mfdl_pkg::DELAY_ONE, 16'sh7FFF, pick_gap());
    send_item(-16'sh8000, mfdl_pkg::DELAY_ONE, -16'sh8000, pick_gap());
    send_item(16'sd5, mfdl_pkg::delay_t'(65537), 16'sd300, pick_gap());
    send_item(-16'sd5, mfdl_pkg::delay_t'(131071), -16'sd300, pick_gap());
    send_item(16'sd300, mfdl_pkg::delay_t'(32768), 16'sh7FFF, pick_gap());
    send_item(-16'sd301, mfdl_pkg::delay_t'(1), -16'sd1, pick_gap());
    send_item(16'sd999, mfdl_pkg::delay_t'(65408), 16'sd1, pick_gap());
    send_item(-16'sd999, mfdl_pkg::delay_t'(65408), -16'sd1, pick_gap());
    send_item(16'sd4, mfdl_pkg::delay_t'(16), 16'sh0180, pick_gap());
    send_item(16'sh5555, mfdl_pkg::delay_t'(65535), 16'shAAAA, pick_gap());
    send_item(16'shAAAA, mfdl_pkg::delay_t'(43690), 16'sh5555, pick_gap());
    send_item(16'sd0, mfdl_pkg::delay_t'(4), -16'sh0040, pick_gap());
    wait_drained();

    // random items, with quiet stretches and one backpressure episode
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 125 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_ITEMS / 2) begin
        hold_req = 1'b1;
        repeat (40) send_item(pick_sample(), pick_delay(), pick_mod(), 0);
        wait_drained();
      end
      send_random();
    end
    wait_drained();

    // back-to-back burst with no idle gaps from the sender and no stalls from the receiver
    quiet = 1'b1;
    for (int i = 0; i < BURST_ITEMS; i++) begin
      send_item(pick_sample(), pick_delay(), pick_mod(), 0);
    end
    quiet = 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("%0d items sent, %0d results checked, %0d mismatches",
             sb.items, sb.taps_checked, sb.errors);
    $display("covered saturated and extreme delays, wide modulation, idle gaps, a long hold");
    $display("on the output, a back-to-back burst; write pointer wrapped %0d times", sb.wraps);
    if (sb.errors == 0) begin
      $display("[modulated_fractional_delay_line_core] OK");
    end else begin
      $display("[modulated_fractional_delay_line_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
